### rtl/core/tkdt_pkg.sv
// ----------------------------------------------------------------------------
// tkdt_pkg: shared types and constants of the two-key dedup table
// Status codes, entry layout, controller states and command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none
package tkdt_pkg;

   localparam logic [29:0] TAG_LIMIT    = 30'd998244353;
   localparam int          BUCKET_LIMIT = 524287;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_RANGE     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // one stored entry, as kept in the ways of a bucket
   typedef struct packed {
      logic [29:0] tag;
      logic [13:0] unique_id;
      logic [14:0] internal_id;
      logic [15:0] count;
      logic [16:0] tree;
      logic [16:0] reference;
      logic        initial_mark;
      logic        external;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_UPDATE,
      S_CLEAR
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear;     // write an empty bucket at the clearing address
      logic capture;   // latch request, launch bucket read
      logic update;    // decide, write back, issue result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;   // clearing address is at the last bucket
   } stat_type;

endpackage
`default_nettype wire

### rtl/core/two_key_dedup_table_core.sv
// ----------------------------------------------------------------------------
// two_key_dedup_table_core: deduplicating table keyed by bucket and tag
// Adds entries with unique and internal ids, updates and finds them.
// ----------------------------------------------------------------------------
// Usage:
//   Request beat: drive req_* and raise start while busy is low; the beat is
//   taken at that edge, which also launches the read of all ways of the
//   bucket (one RAM per way, registered read); busy is high in the lookup and update states.
//   The lookup state reads the bucket again from the latched request.
//   The update state compares tags in parallel, writes back the chosen way and
//   registers the result.
//   Result beat: rsp_valid is registered at the end of the update state and
//   the beat is then taken; the receiver cannot stall.
//   Requests: a new one is taken only after the last has written back, since
//   the single port of each way RAM serves its read and then its write.
//   Reset: synchronous; clears both id counters, then a clearing pass writes
//   every bucket empty, one per cycle, holding busy high after reset drops
//   until the last bucket is written.
// ----------------------------------------------------------------------------
`default_nettype none
module two_key_dedup_table_core #(
   parameter int BUCKETS = 4096,
   parameter int WAYS    = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire logic          req_mode,
   input  wire logic [11:0]   req_bucket,
   input  wire logic [29:0]   req_tag,
   input  wire logic [15:0]   req_tree_number,
   input  wire logic          req_from_reference,
   input  wire logic          req_external_flag,
   input  wire logic [15:0]   req_reference_number,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [13:0]        rsp_unique_id,
   output logic signed [14:0] rsp_internal_id,
   output logic [15:0]        rsp_seen_count,
   output logic signed [16:0] rsp_last_tree,
   output logic               rsp_initial_mark,
   output logic signed [16:0] rsp_stored_reference,
   output logic               rsp_stored_external
);
   import tkdt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   tkdt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .stat(stat),
      .busy(busy), .cmd(cmd));

   tkdt_datapath #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_mode(req_mode), .req_bucket(req_bucket), .req_tag(req_tag),
      .req_tree_number(req_tree_number), .req_from_reference(req_from_reference),
      .req_external_flag(req_external_flag),
      .req_reference_number(req_reference_number),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_unique_id(rsp_unique_id), .rsp_internal_id(rsp_internal_id),
      .rsp_seen_count(rsp_seen_count), .rsp_last_tree(rsp_last_tree),
      .rsp_initial_mark(rsp_initial_mark),
      .rsp_stored_reference(rsp_stored_reference),
      .rsp_stored_external(rsp_stored_external));
endmodule
`default_nettype wire

### rtl/core/tkdt_ram.sv
// ----------------------------------------------------------------------------
// tkdt_ram: generic single-port RAM with registered read
// One access per cycle; a write does not update the read data.
// ----------------------------------------------------------------------------
`default_nettype none
module tkdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

### rtl/core/tkdt_ctrl.sv
// ----------------------------------------------------------------------------
// tkdt_ctrl: sequencer of the dedup table
// Clearing pass after reset, then idle, bucket read, decide and write back.
// ----------------------------------------------------------------------------
`default_nettype none
module tkdt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire tkdt_pkg::stat_type stat,
   output logic                   busy,
   output tkdt_pkg::cmd_type      cmd
);
   import tkdt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

   // next state: every request takes the same path, idle to lookup to update and back to idle
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:  if (stat.clear_last) state_in = S_IDLE;
         S_IDLE:   if (start) state_in = S_LOOKUP;
         S_LOOKUP: state_in = S_UPDATE;
         S_UPDATE: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd     = '0;
      busy    = 1'b1;
      unique case (state_ff)
         S_CLEAR:  cmd.clear = 1'b1;
         S_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         S_LOOKUP: ;
         S_UPDATE: cmd.update = 1'b1;
      endcase
   end
endmodule
`default_nettype wire

### rtl/core/tkdt_datapath.sv
// ----------------------------------------------------------------------------
// tkdt_datapath: bucket memories, tag compare, entry update and id counters
// Each way has its own RAM, addressed by bucket; the valid bit tops each word.
// ----------------------------------------------------------------------------
`default_nettype none
module tkdt_datapath #(
   parameter int BUCKETS = 4096,
   parameter int WAYS    = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tkdt_pkg::cmd_type  cmd,
   output tkdt_pkg::stat_type      stat,
   input  wire logic               req_mode,
   input  wire logic [11:0]        req_bucket,
   input  wire logic [29:0]        req_tag,
   input  wire logic [15:0]        req_tree_number,
   input  wire logic               req_from_reference,
   input  wire logic               req_external_flag,
   input  wire logic [15:0]        req_reference_number,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic [13:0]             rsp_unique_id,
   output logic signed [14:0]      rsp_internal_id,
   output logic [15:0]             rsp_seen_count,
   output logic signed [16:0]      rsp_last_tree,
   output logic                    rsp_initial_mark,
   output logic signed [16:0]      rsp_stored_reference,
   output logic                    rsp_stored_external
);
   import tkdt_pkg::*;

   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int RW = ENTRY_W + 1;

   // latched request
   logic        mode_ff, ref_ff, ext_ff, range_ff;
   logic [BW-1:0] bucket_ff;
   logic [29:0] tag_ff;
   logic [15:0] tree_ff, refnum_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff   <= req_mode;
         bucket_ff <= BW'(req_bucket);
         tag_ff    <= req_tag;
         tree_ff   <= req_tree_number;
         ref_ff    <= req_from_reference;
         ext_ff    <= req_external_flag;
         refnum_ff <= req_reference_number;
         range_ff  <= (32'(req_bucket) < 32'(BUCKETS)) &&
                      (32'(req_bucket) < 32'(BUCKET_LIMIT)) &&
                      (req_tag < TAG_LIMIT);
      end
   end

   // clearing pass after reset: one bucket per cycle
   logic [BW-1:0] clr_ff;
   always_ff @(posedge clock) begin
      if (reset)          clr_ff <= '0;
      else if (cmd.clear) clr_ff <= clr_ff + 1'b1;
   end
   assign stat.clear_last = (clr_ff == BW'(BUCKETS - 1));

   // address: clearing counter, request in idle, latched afterwards
   logic [BW-1:0] addr;
   assign addr = cmd.clear ? clr_ff : (cmd.capture ? BW'(req_bucket) : bucket_ff);

   logic [RW-1:0]   rd_word [WAYS];
   entry_type       rd      [WAYS];
   logic            vld     [WAYS];
   logic [WAYS-1:0] we;
   entry_type       wr_entry;
   logic [RW-1:0]   wdata;

   // valid bit on top of the entry; clearing writes an empty word
   assign wdata = cmd.clear ? '0 : {1'b1, wr_entry};

   for (genvar w = 0; w < WAYS; w++) begin : g_way
      tkdt_ram #(.WIDTH(RW), .DEPTH(BUCKETS)) u_ram (
         .clock(clock), .we(we[w]), .addr(addr),
         .wdata(wdata), .rdata(rd_word[w]));
      assign vld[w] = rd_word[w][RW-1];
      assign rd[w]  = rd_word[w][ENTRY_W-1:0];
   end

   // tag compare and lowest free way
   logic hit, have_free;
   logic [$clog2(WAYS+1)-1:0] hit_way, free_way;
   always_comb begin
      hit = 1'b0; have_free = 1'b0; hit_way = '0; free_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (vld[w]) begin
            if (!hit && rd[w].tag == tag_ff) begin
               hit = 1'b1; hit_way = ($clog2(WAYS+1))'(w);
            end
         end else if (!have_free) begin
            have_free = 1'b1; free_way = ($clog2(WAYS+1))'(w);
         end
      end
   end

   logic [14:0] uniq_ff, uniq_in, intl_ff, intl_in;
   always_ff @(posedge clock) begin
      if (reset) begin
         uniq_ff <= '0; intl_ff <= '0;
      end else begin
         uniq_ff <= uniq_in; intl_ff <= intl_in;
      end
   end

   // decide status and the updated entry
   status_type st;
   entry_type  cur;
   logic       do_write;
   logic [$clog2(WAYS+1)-1:0] sel;
   always_comb begin
      uniq_in  = uniq_ff;
      intl_in  = intl_ff;
      do_write = 1'b0;
      sel      = hit ? hit_way : free_way;
      cur      = rd[0];
      for (int w = 0; w < WAYS; w++)
         if (sel == ($clog2(WAYS+1))'(w)) cur = rd[w];
      priority if (!range_ff) st = ST_RANGE;
      else if (mode_ff) st = hit ? ST_OK : ST_NOT_FOUND;
      else if (!hit && !have_free) st = ST_FULL;
      else st = ST_OK;
      wr_entry = cur;
      if (range_ff && !mode_ff && (hit || have_free)) begin
         do_write = cmd.update;
         if (!hit) begin
            wr_entry.tag          = tag_ff;
            wr_entry.unique_id    = uniq_ff[13:0];
            wr_entry.internal_id  = '1;
            wr_entry.count        = '0;
            wr_entry.tree         = '1;
            wr_entry.reference    = '1;
            wr_entry.initial_mark = 1'b0;
            wr_entry.external     = ext_ff;
            if (cmd.update) uniq_in = uniq_ff + 15'd1;
         end
         if (ref_ff) begin
            wr_entry.initial_mark = 1'b1;
            wr_entry.reference    = {1'b0, refnum_ff};
         end else begin
            if (wr_entry.count == 16'd0 && !ext_ff) begin
               wr_entry.internal_id = {1'b0, intl_ff[13:0]};
               if (cmd.update) intl_in = intl_ff + 15'd1;
            end
            if (wr_entry.count != 16'hFFFF) wr_entry.count = wr_entry.count + 16'd1;
            wr_entry.tree = {1'b0, tree_ff};
         end
      end
      for (int w = 0; w < WAYS; w++)
         we[w] = cmd.clear || (do_write && (sel == ($clog2(WAYS+1))'(w)));
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= cmd.update;
   end
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_status <= st;
         if (st == ST_OK) begin
            rsp_unique_id        <= wr_entry.unique_id;
            rsp_internal_id      <= wr_entry.internal_id;
            rsp_seen_count       <= wr_entry.count;
            rsp_last_tree        <= wr_entry.tree;
            rsp_initial_mark     <= wr_entry.initial_mark;
            rsp_stored_reference <= wr_entry.reference;
            rsp_stored_external  <= wr_entry.external;
         end else begin
            rsp_unique_id        <= '0;
            rsp_internal_id      <= '0;
            rsp_seen_count       <= '0;
            rsp_last_tree        <= '0;
            rsp_initial_mark     <= 1'b0;
            rsp_stored_reference <= '0;
            rsp_stored_external  <= 1'b0;
         end
      end
   end
endmodule
`default_nettype wire

### rtl/core/tkdt_checker.sv
// ----------------------------------------------------------------------------
// tkdt_checker: port-level checks of the dedup table
// Request/result pairing and cleared fields on error status.
// ----------------------------------------------------------------------------
`default_nettype none
module tkdt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [1:0]  rsp_status,
   input wire logic [13:0] rsp_unique_id,
   input wire logic [15:0] rsp_seen_count
);
   import tkdt_pkg::*;

   // a taken beat yields its result after the lookup and update states
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid) else $error("result missing");

   // no result without a request beat
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 3)) else $error("spurious result");

   // busy while an item is in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy low in flight");

   // error status clears the unique id and the seen count
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (rsp_unique_id == '0 && rsp_seen_count == '0))
      else $error("payload not cleared");
endmodule

bind two_key_dedup_table_core tkdt_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status),
   .rsp_unique_id(rsp_unique_id), .rsp_seen_count(rsp_seen_count));
`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for two_key_dedup_table_core
// Drives add and find beats, predicts each result from a local copy of the
// table, and compares every result beat field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import tkdt_pkg::*;

   localparam int NBUCKETS  = 4096;
   localparam int NWAYS     = 4;
   localparam int CYCLE_CAP = 400000;

   typedef struct packed {
      logic [1:0]         status;
      logic [13:0]        unique_id;
      logic signed [14:0] internal_id;
      logic [15:0]        seen_count;
      logic signed [16:0] last_tree;
      logic               initial_mark;
      logic signed [16:0] stored_reference;
      logic               stored_external;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_mode = 1'b0;
   logic [11:0] req_bucket = '0;
   logic [29:0] req_tag = '0;
   logic [15:0] req_tree_number = '0;
   logic        req_from_reference = 1'b0;
   logic        req_external_flag = 1'b0;
   logic [15:0] req_reference_number = '0;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic [13:0]        rsp_unique_id;
   logic signed [14:0] rsp_internal_id;
   logic [15:0]        rsp_seen_count;
   logic signed [16:0] rsp_last_tree;
   logic               rsp_initial_mark;
   logic signed [16:0] rsp_stored_reference;
   logic               rsp_stored_external;

   two_key_dedup_table_core DUT (.*);

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // local copy of the table
   logic        tbl_valid [NBUCKETS*NWAYS];
   entry_type   tbl_entry [NBUCKETS*NWAYS];
   logic [14:0] next_unique;
   logic [14:0] next_internal;
   result_type  expected_results [$];
   logic [29:0] used_tags [$];
   bit          failed;
   int unsigned cycles;
   bit          quiet;

   function automatic result_type entry_result(entry_type e);
      result_type r;
      r.status           = ST_OK;
      r.unique_id        = e.unique_id;
      r.internal_id      = e.internal_id;
      r.seen_count       = e.count;
      r.last_tree        = e.tree;
      r.initial_mark     = e.initial_mark;
      r.stored_reference = e.reference;
      r.stored_external  = e.external;
      return r;
   endfunction

   // predict one beat and update the local table
   function automatic result_type predict_table_op(logic md, logic [11:0] bk,
         logic [29:0] tg, logic [15:0] tr, logic isref, logic isext,
         logic [15:0] rn);
      result_type r;
      int slot, free_slot;
      r = '0;
      slot = -1;
      free_slot = -1;
      if (bk >= NBUCKETS || bk >= BUCKET_LIMIT || tg >= TAG_LIMIT) begin
         r.status = ST_RANGE;
         return r;
      end
      for (int w = 0; w < NWAYS; w++) begin
         int i;
         i = bk*NWAYS + w;
         if (tbl_valid[i]) begin
            if (slot < 0 && tbl_entry[i].tag == tg) slot = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (md) begin
         if (slot < 0) r.status = ST_NOT_FOUND;
         else r = entry_result(tbl_entry[slot]);
         return r;
      end
      if (slot < 0) begin
         if (free_slot < 0) begin
            r.status = ST_FULL;
            return r;
         end
         slot = free_slot;
         tbl_valid[slot] = 1'b1;
         tbl_entry[slot] = '0;
         tbl_entry[slot].tag         = tg;
         tbl_entry[slot].unique_id   = next_unique[13:0];
         tbl_entry[slot].internal_id = '1;
         tbl_entry[slot].tree        = '1;
         tbl_entry[slot].reference   = '1;
         tbl_entry[slot].external    = isext;
         next_unique = next_unique + 1'b1;
      end
      if (isref) begin
         tbl_entry[slot].initial_mark = 1'b1;
         tbl_entry[slot].reference    = {1'b0, rn};
      end else begin
         if (tbl_entry[slot].count == 0 && !isext) begin
            tbl_entry[slot].internal_id = {1'b0, next_internal[13:0]};
            next_internal = next_internal + 1'b1;
         end
         if (tbl_entry[slot].count != 16'hFFFF)
            tbl_entry[slot].count = tbl_entry[slot].count + 1'b1;
         tbl_entry[slot].tree = {1'b0, tr};
      end
      return entry_result(tbl_entry[slot]);
   endfunction

   // random sender gap: start drops only while idling
   task automatic sender_gap();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // send one request beat, wait for acceptance
   task automatic send_beat(logic md, logic [11:0] bk, logic [29:0] tg,
         logic [15:0] tr, logic isref, logic isext, logic [15:0] rn);
      req_mode             <= md;
      req_bucket           <= bk;
      req_tag              <= tg;
      req_tree_number      <= tr;
      req_from_reference   <= isref;
      req_external_flag    <= isext;
      req_reference_number <= rn;
      start                <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_results.push_back(predict_table_op(md, bk, tg, tr, isref, isext, rn));
      sender_gap();
   endtask

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $error("result beat with nothing expected");
            failed = 1'b1;
         end else begin
            result_type e;
            e = expected_results.pop_front();
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status); failed = 1'b1;
            end
            if (rsp_unique_id !== e.unique_id) begin
               $error("unique_id exp %0d got %0d", e.unique_id, rsp_unique_id);
               failed = 1'b1;
            end
            if (rsp_internal_id !== e.internal_id) begin
               $error("internal_id exp %0d got %0d", e.internal_id, rsp_internal_id);
               failed = 1'b1;
            end
            if (rsp_seen_count !== e.seen_count) begin
               $error("seen_count exp %0d got %0d", e.seen_count, rsp_seen_count);
               failed = 1'b1;
            end
            if (rsp_last_tree !== e.last_tree) begin
               $error("last_tree exp %0d got %0d", e.last_tree, rsp_last_tree);
               failed = 1'b1;
            end
            if (rsp_initial_mark !== e.initial_mark) begin
               $error("initial_mark exp %0d got %0d", e.initial_mark, rsp_initial_mark);
               failed = 1'b1;
            end
            if (rsp_stored_reference !== e.stored_reference) begin
               $error("stored_reference exp %0d got %0d", e.stored_reference,
                      rsp_stored_reference);
               failed = 1'b1;
            end
            if (rsp_stored_external !== e.stored_external) begin
               $error("stored_external exp %0d got %0d", e.stored_external,
                      rsp_stored_external);
               failed = 1'b1;
            end
         end
      end
   end

   function automatic logic [29:0] rand_tag();
      return 30'($urandom_range(0, 998244352));
   endfunction

   // extremes of fields, range errors, full bucket, not found
   task automatic test_directed();
      logic [29:0] t;
      send_beat(1'b1, 12'd0, 30'd0, 16'd0, 1'b0, 1'b0, 16'd0);          // find miss
      send_beat(1'b0, 12'd0, TAG_LIMIT, 16'd1, 1'b0, 1'b0, 16'd1);      // tag at limit
      send_beat(1'b1, 12'hFFF, 30'h3FFFFFFF, 16'd1, 1'b1, 1'b1, 16'd1); // tag max
      send_beat(1'b0, 12'd0, 30'd0, 16'hFFFF, 1'b0, 1'b0, 16'd0);
      send_beat(1'b0, 12'd0, 30'd0, 16'd0, 1'b1, 1'b1, 16'hFFFF);
      send_beat(1'b0, 12'hFFF, TAG_LIMIT - 30'd1, 16'hAAAA, 1'b0, 1'b1, 16'h5555);
      send_beat(1'b0, 12'hFFF, TAG_LIMIT - 30'd1, 16'h5555, 1'b0, 1'b0, 16'hAAAA);
      send_beat(1'b1, 12'hFFF, TAG_LIMIT - 30'd1, 16'd0, 1'b0, 1'b0, 16'd0);
      // fill bucket 7 then overflow it
      for (int k = 0; k < NWAYS + 1; k++)
         send_beat(1'b0, 12'd7, 30'(100 + k), 16'(k), k[0], k[1], 16'(k));
      send_beat(1'b1, 12'd7, 30'(100 + NWAYS), 16'd0, 1'b0, 1'b0, 16'd0);
      send_beat(1'b1, 12'd7, 30'd101, 16'd0, 1'b0, 1'b0, 16'd0);
      // ext entry then input add: no internal id
      t = 30'h2AAAAAAA;
      send_beat(1'b0, 12'd9, t, 16'd3, 1'b0, 1'b1, 16'd0);
      send_beat(1'b0, 12'd9, t, 16'd4, 1'b0, 1'b1, 16'd0);
      send_beat(1'b0, 12'd9, t, 16'd5, 1'b1, 1'b0, 16'd77);
   endtask

   // repeated input adds on one entry, count climbs each time
   task automatic test_repeated_adds();
      for (int k = 0; k < 30; k++)
         send_beat(1'b0, 12'd11, 30'h15555555, 16'(k), 1'b0, 1'b0, 16'd0);
   endtask

   // random mix, biased to revisit known tags
   task automatic test_random(int n);
      logic [11:0] bk;
      logic [29:0] tg;
      for (int k = 0; k < n; k++) begin
         bk = $urandom_range(0, 15) == 0 ? 12'($urandom) : 12'($urandom_range(0, 31));
         case ($urandom_range(0, 9))
            0:       tg = 30'(30'($urandom_range(0, 63)) + TAG_LIMIT +
                          $urandom_range(0, 1) * 30'($urandom_range(0, 75497470)));
            1, 2, 3: tg = rand_tag();
            default: tg = used_tags.size() ? used_tags[$urandom_range(0, used_tags.size()-1)]
                                           : rand_tag();
         endcase
         if (tg < TAG_LIMIT && used_tags.size() < 64) used_tags.push_back(tg);
         if (k > n - 200) quiet = 1'b1;
         send_beat($urandom_range(0, 3) == 0, bk, tg, 16'($urandom),
                   1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, 16'($urandom));
      end
   endtask

   initial begin
      failed = 1'b0;
      cycles = 0;
      quiet = 1'b0;
      next_unique = '0;
      next_internal = '0;
      for (int i = 0; i < NBUCKETS*NWAYS; i++) tbl_valid[i] = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1700);
      test_repeated_adds();
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (!failed) $display("testbench: PASS");
      else $display("testbench: FAIL");
      $finish;
   end
endmodule
`default_nettype wire
